### rtl/arw_pkg.sv
// arw_pkg: shared types and constants of the anti-replay window
// no dependencies; imported by every module of the block

package arw_pkg;

	// fixed field widths
	localparam int unsigned SEQ_W  = 64;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned DIST_W = 32;
	localparam int unsigned BIT_W  = 6;
	localparam int unsigned OUT_W  = 72;

	// item kinds carried on the input tuser
	localparam logic CMD_CHECK  = 1'b0;
	localparam logic CMD_ACCEPT = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_LOAD,
		ST_SHIFT,
		ST_TEST,
		ST_SET,
		ST_RESP
	} state_t;

	// operations of the shared funnel unit
	typedef enum logic {
		FN_SHIFT,
		FN_MARK
	} fn_op_t;

	// bitmap memory control
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_all;
	} mem_ctl_t;

endpackage

### rtl/arw_funnel.sv
// arw_funnel: shared word unit of the window, funnel shift, bit mark and bit test
// depends on arw_pkg

module arw_funnel import arw_pkg::*; (
	input  fn_op_t              op,
	input  logic [WORD_W-1:0]   hi,
	input  logic [WORD_W-1:0]   lo,
	input  logic [BIT_W-1:0]    amt,
	input  logic                set_low,
	output logic [WORD_W-1:0]   word,
	output logic                hit
);

	logic [WORD_W-1:0] up;
	logic [WORD_W-1:0] carry;

	// funnel of two adjacent words, lower word feeds the vacated bits
	always_comb begin
		up    = hi << amt;
		carry = (amt == '0) ? '0 : (lo >> (7'd64 - {1'b0, amt}));
		case (op)
			FN_SHIFT: word = up | carry | {{(WORD_W-1){1'b0}}, set_low};
			FN_MARK:  word = lo | ({{(WORD_W-1){1'b0}}, 1'b1} << amt);
			default:  word = lo;
		endcase
	end

	// single bit test of the lower word
	assign hit = lo[amt];

endmodule

### rtl/arw_mem.sv
// arw_mem: bitmap word memory with a valid bit per word
// depends on arw_pkg; a word that is not valid reads as zero

module arw_mem import arw_pkg::*; #(
	parameter int unsigned NWORDS = 16,
	parameter int unsigned AW     = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_ctl_t          ctl,
	input  logic [AW-1:0]     raddr,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem_q [NWORDS];
	logic [WORD_W-1:0] rd_q;
	logic [NWORDS-1:0] vld_q;
	logic [NWORDS-1:0] vld_nxt;
	logic              rok_q;

	// storage, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rd_q <= mem_q[raddr];
		end
	end

	// next valid bits, a clear drops all of them at once
	always_comb begin
		vld_nxt = ctl.clr_all ? '0 : vld_q;
		if (ctl.wr_en) begin
			vld_nxt[waddr] = 1'b1;
		end
	end

	// valid bits and read qualifier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rok_q <= 1'b0;
		end else begin
			vld_q <= vld_nxt;
			rok_q <= ctl.rd_en & vld_q[raddr];
		end
	end

	assign rdata = rok_q ? rd_q : '0;

endmodule

### rtl/anti_replay_window.sv
// anti_replay_window: sliding-window replay check over 64-bit sequence numbers
// depends on arw_pkg, arw_mem, arw_funnel
//
// channel   dir  handshake          payload
// s_*       in   tvalid / tready    tdata = iv, tuser = cmd
// m_*       out  tvalid / tready    tdata = is_fresh, offset
// cfg_*     in   cfg_we             cfg_wdata = initial_remote
//
// an item either touches no word or only rewrites word zero,
// or reads one word to test or mark it,
// or, when a newer accept shifts the bitmap, rewrites every word;
// the shift runs word by word through the one funnel unit and the one memory port pair.
// reset and a register write clear the bitmap at once through the per-word valid bits.
// the result waits in an output register; a stalled output holds the next item in the
// result state, input is not ready while an item is in work.

module anti_replay_window import arw_pkg::*; #(
	parameter int unsigned WINDOW_BITS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [SEQ_W-1:0]  s_tdata,   // [63:0] iv
	input  logic [0:0]        s_tuser,   // [0] cmd
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // [0] is_fresh, [64:1] offset, [71:65] zero
	input  logic              cfg_we,
	input  logic [SEQ_W-1:0]  cfg_wdata
);

	localparam int unsigned NWORDS = (WINDOW_BITS + 63) / 64;
	localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam logic [AW-1:0]     LAST = AW'(NWORDS - 1);
	localparam logic [DIST_W-1:0] WIN  = DIST_W'(WINDOW_BITS);

	state_t state_q, nxt;

	logic [SEQ_W-1:0]  init_q, high_q, iv_q, offset_q, out_offset_q;
	logic [DIST_W-1:0] ahead_q;
	logic [WORD_W-1:0] hi_q;
	logic [AW-1:0]     idx_q;
	logic              cmd_q, fresh_q, out_vld_q, out_fresh_q;

	logic [DIST_W-1:0] back;
	logic              newer, ahead_in_win, back_in_win;
	logic [AW-1:0]     ws, bword;
	logic [BIT_W-1:0]  bs, bbit;
	logic [AW:0]       jpos, rpos;

	mem_ctl_t          ctl;
	logic [AW-1:0]     raddr, waddr;
	logic [WORD_W-1:0] wdata, rd_eff, fn_word;
	logic              wsel_one, fn_set, fn_hit;
	fn_op_t            fn_op;
	logic [BIT_W-1:0]  fn_amt;

	// distance decode
	assign back         = '0 - ahead_q;
	assign newer        = (ahead_q != '0) && !ahead_q[DIST_W-1];
	assign ahead_in_win = ahead_q < WIN;
	assign back_in_win  = back < WIN;
	assign ws           = ahead_q[BIT_W +: AW];
	assign bs           = ahead_q[BIT_W-1:0];
	assign bword        = back[BIT_W +: AW];
	assign bbit         = back[BIT_W-1:0];

	// source word of the shift for the next target word, negative means below the bitmap
	assign jpos = (state_q == ST_LOAD) ? {1'b0, idx_q} : ({1'b0, idx_q} - 1'b1);
	assign rpos = jpos - {1'b0, ws} - 1'b1;

	// sequencer
	always_comb begin
		nxt         = state_q;
		ctl         = '0;
		ctl.clr_all = cfg_we;
		raddr       = '0;
		waddr       = idx_q;
		wsel_one    = 1'b0;
		fn_op       = FN_SHIFT;
		fn_amt      = bs;
		fn_set      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) nxt = ST_CALC;
			end
			ST_CALC: begin
				if (cmd_q == CMD_CHECK) begin
					if (back_in_win) begin
						ctl.rd_en = 1'b1;
						raddr     = bword;
						nxt       = ST_TEST;
					end else begin
						nxt = ST_RESP;
					end
				end else if (newer) begin
					if (!ahead_in_win) begin
						ctl.wr_en   = 1'b1;
						ctl.clr_all = 1'b1;
						waddr       = '0;
						wsel_one    = 1'b1;
						nxt         = ST_RESP;
					end else begin
						ctl.rd_en = 1'b1;
						raddr     = LAST - ws;
						nxt       = ST_LOAD;
					end
				end else if (back_in_win) begin
					ctl.rd_en = 1'b1;
					raddr     = bword;
					nxt       = ST_SET;
				end else begin
					nxt = ST_RESP;
				end
			end
			ST_LOAD: begin
				ctl.rd_en = !rpos[AW];
				raddr     = rpos[AW-1:0];
				nxt       = ST_SHIFT;
			end
			ST_SHIFT: begin
				ctl.wr_en = 1'b1;
				fn_set    = (idx_q == '0);
				if (idx_q == '0) begin
					nxt = ST_RESP;
				end else begin
					ctl.rd_en = !rpos[AW];
					raddr     = rpos[AW-1:0];
				end
			end
			ST_TEST: begin
				fn_amt = bbit;
				nxt    = ST_RESP;
			end
			ST_SET: begin
				fn_op     = FN_MARK;
				fn_amt    = bbit;
				ctl.wr_en = 1'b1;
				waddr     = bword;
				nxt       = ST_RESP;
			end
			ST_RESP: begin
				if (!out_vld_q || m_tready) nxt = ST_IDLE;
			end
			default: nxt = ST_IDLE;
		endcase
	end

	assign wdata = wsel_one ? {{(WORD_W-1){1'b0}}, 1'b1} : fn_word;

	// state, window origin and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			init_q    <= '0;
			high_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cfg_we) begin
				init_q <= cfg_wdata;
				high_q <= cfg_wdata;
			end else if (state_q == ST_CALC && cmd_q == CMD_ACCEPT && newer) begin
				high_q <= iv_q;
			end
			if (state_q == ST_RESP && (!out_vld_q || m_tready)) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// item registers and shift carry
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			cmd_q    <= s_tuser[0];
			iv_q     <= s_tdata;
			ahead_q  <= s_tdata[DIST_W-1:0] - high_q[DIST_W-1:0];
			offset_q <= s_tdata - init_q;
		end
		case (state_q)
			ST_CALC: begin
				fresh_q <= back[DIST_W-1];
				idx_q   <= LAST;
			end
			ST_LOAD: hi_q <= rd_eff;
			ST_SHIFT: begin
				hi_q <= rd_eff;
				if (idx_q != '0) idx_q <= idx_q - 1'b1;
			end
			ST_TEST: fresh_q <= !fn_hit;
			ST_RESP: begin
				if (!out_vld_q || m_tready) begin
					out_fresh_q  <= (cmd_q == CMD_CHECK) ? fresh_q : 1'b0;
					out_offset_q <= (cmd_q == CMD_ACCEPT) ? offset_q : '0;
				end
			end
			default: ;
		endcase
	end

	arw_mem #(
		.NWORDS(NWORDS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.raddr (raddr),
		.waddr (waddr),
		.wdata (wdata),
		.rdata (rd_eff)
	);

	arw_funnel u_fn (
		.op     (fn_op),
		.hi     (hi_q),
		.lo     (rd_eff),
		.amt    (fn_amt),
		.set_low(fn_set),
		.word   (fn_word),
		.hit    (fn_hit)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_W-SEQ_W-1){1'b0}}, out_offset_q, out_fresh_q};

endmodule

### rtl/arw_checker.sv
// arw_checker: port-level checks of the anti-replay window
// depends on arw_pkg; bound to anti_replay_window below

module arw_checker import arw_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// one item at a time: input closes after an accepted item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after an accepted item");

	// no result appears in the cycle right after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result raised one cycle after accept");

	// a check carries no offset and an accept carries no fresh flag
	a_exclusive_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && (m_tdata[64:1] != '0)))
		else $error("fresh flag and offset both set");

	// a stalled result holds
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind anti_replay_window arw_checker u_arw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
